// ===== sv/tsbbh_pkg.sv =====
package tsbbh_pkg;

  // transport stream constants
  localparam logic [7:0] TS_SYNC     = 8'h47;
  localparam logic [7:0] TS_LEN      = 8'd188;
  localparam logic [7:0] CRC8_GEN    = 8'hD5;
  localparam logic [15:0] UPL_TS     = 16'd1504;
  localparam int         INBAND_BITS = 104;
  localparam int         HDR_BYTES   = 10;
  localparam int         INB_BYTES   = 13;
  localparam int         CNT_W       = 4;

  // byte kind codes
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_INB  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_DFB  = 3'd0;
  localparam logic [2:0] REG_HE   = 3'd1;
  localparam logic [2:0] REG_IBEN = 3'd2;
  localparam logic [2:0] REG_FPG  = 3'd3;
  localparam logic [2:0] REG_RATE = 3'd4;
  localparam logic [2:0] REG_RO   = 3'd5;
  localparam logic [2:0] REG_S2X  = 3'd6;
  localparam logic [2:0] REG_MAT  = 3'd7;

  // output sequencer segment
  typedef enum logic [2:0] {
    SEG_HDR = 3'b001,
    SEG_DAT = 3'b010,
    SEG_INB = 3'b100
  } seg_e;

  // crc-8, msb first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC8_GEN;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  // one byte of the in-band type b field
  function automatic logic [7:0] inband_byte(input logic [26:0] rate,
                                             input logic [CNT_W-1:0] idx);
    logic [103:0] f;
    f = {2'b01, 65'd0, rate, 10'd0};
    return f[7'(103 - 8 * int'(idx)) -: 8];
  endfunction

endpackage

// ===== sv/ts_baseband_header_inserter_unit.sv =====
// channel | direction | fields                                      | handshake
// in      | input     | ts_byte_i                                   | in_valid_i / in_stall_o
// out     | output    | out_byte_o byte_kind_o last_of_run_o sync_error_o | out_valid_o / out_stall_i
// config  | input     | eight registers at byte address 4*i         | apb, pready always high
//
// one ts word is accepted per cycle while only data words come out and out_stall_i is low;
// a word that opens a frame holds the input while its ten header words go out, a frame end
// with in-band signalling while thirteen more go out, as the output register sends one word a cycle when not stalled.
// the input is taken in the cycle the last word of the previous run leaves.
// reset clears all frame, packet and group state; no clearing pass is needed.
module ts_baseband_header_inserter_unit #(
  parameter int MAX_FRAME_BYTES = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ts_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  byte_kind_o,
  output logic        last_of_run_o,
  output logic        sync_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int FBC_W = $clog2(MAX_FRAME_BYTES);
  localparam logic [12:0] PB_MAX = 13'(MAX_FRAME_BYTES - 23);

  // configuration registers
  logic [15:0] cfg_dfb_q;
  logic        cfg_he_q;
  logic        cfg_iben_q;
  logic [7:0]  cfg_fpg_q;
  logic [26:0] cfg_rate_q;
  logic [1:0]  cfg_ro_q;
  logic        cfg_s2x_q;
  logic [5:0]  cfg_mat_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_dfb_q  <= 16'd32128;
      cfg_he_q   <= 1'b0;
      cfg_iben_q <= 1'b0;
      cfg_fpg_q  <= 8'd1;
      cfg_rate_q <= '0;
      cfg_ro_q   <= '0;
      cfg_s2x_q  <= 1'b0;
      cfg_mat_q  <= 6'd60;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tsbbh_pkg::REG_DFB:  cfg_dfb_q  <= pwdata[15:0];
        tsbbh_pkg::REG_HE:   cfg_he_q   <= pwdata[0];
        tsbbh_pkg::REG_IBEN: cfg_iben_q <= pwdata[0];
        tsbbh_pkg::REG_FPG:  cfg_fpg_q  <= pwdata[7:0];
        tsbbh_pkg::REG_RATE: cfg_rate_q <= pwdata[26:0];
        tsbbh_pkg::REG_RO:   cfg_ro_q   <= pwdata[1:0];
        tsbbh_pkg::REG_S2X:  cfg_s2x_q  <= pwdata[0];
        tsbbh_pkg::REG_MAT:  cfg_mat_q  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      tsbbh_pkg::REG_DFB:  prdata = {16'd0, cfg_dfb_q};
      tsbbh_pkg::REG_HE:   prdata = {31'd0, cfg_he_q};
      tsbbh_pkg::REG_IBEN: prdata = {31'd0, cfg_iben_q};
      tsbbh_pkg::REG_FPG:  prdata = {24'd0, cfg_fpg_q};
      tsbbh_pkg::REG_RATE: prdata = {5'd0, cfg_rate_q};
      tsbbh_pkg::REG_RO:   prdata = {30'd0, cfg_ro_q};
      tsbbh_pkg::REG_S2X:  prdata = {31'd0, cfg_s2x_q};
      tsbbh_pkg::REG_MAT:  prdata = {26'd0, cfg_mat_q};
      default:             prdata = '0;
    endcase
  end

  // stream state
  logic [7:0]       pos_q, pos_d;
  logic [7:0]       pcrc_q, pcrc_d;
  logic [FBC_W-1:0] fbc_q, fbc_d;
  logic [7:0]       grp_q, grp_d;
  logic             tog_q, tog_d;
  logic             pend_q, pend_d;

  // run held in the output register
  logic                       run_vld_q, run_vld_d;
  logic                       run_dat_q, run_inb_q, run_err_q;
  logic [7:0]                 run_byte_q, run_m1_q;
  logic [15:0]                run_dfl_q;
  logic [10:0]                run_syncd_q;
  tsbbh_pkg::seg_e            seg_q, seg_d;
  logic [tsbbh_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]                 hcrc_q, hcrc_d;

  logic in_acc, out_acc, run_last;

  // decode of the incoming word
  logic        at_start, err, hdr_due, has_data, inb_now, frame_end, run_any;
  logic [7:0]  data_b;
  logic [1:0]  ro;
  logic [15:0] len;
  logic [12:0] pb_raw, pb;
  logic [FBC_W-1:0] fbc_base, fbc_inc;
  logic [8:0]  grp_inc;
  logic [10:0] syncd;

  assign at_start = (pos_q == '0);
  assign err      = pend_q | (at_start & (ts_byte_i != tsbbh_pkg::TS_SYNC));
  assign hdr_due  = (fbc_q == '0);
  assign has_data = !(at_start & cfg_he_q);
  assign data_b   = at_start ? pcrc_q : ts_byte_i;
  assign inb_now  = cfg_iben_q & (grp_q == '0);
  assign run_any  = hdr_due | has_data;

  // payload length in bytes for the current frame
  always_comb begin
    len = {cfg_dfb_q[15:3], 3'b000};
    if (inb_now) begin
      if (len < 16'(tsbbh_pkg::INBAND_BITS + 8)) begin
        len = 16'd8;
      end else begin
        len = len - 16'(tsbbh_pkg::INBAND_BITS);
      end
    end else if (len < 16'd8) begin
      len = 16'd8;
    end
    pb_raw = len[15:3];
    pb     = (pb_raw > PB_MAX) ? PB_MAX : pb_raw;
  end

  assign fbc_base  = hdr_due ? FBC_W'(tsbbh_pkg::HDR_BYTES) : fbc_q;
  assign fbc_inc   = fbc_base + FBC_W'(1);
  assign frame_end = has_data &
                     (13'(fbc_inc - FBC_W'(tsbbh_pkg::HDR_BYTES)) >= pb);
  assign grp_inc   = {1'b0, grp_q} + 9'd1;
  assign syncd     = at_start ? 11'd0 : {8'(tsbbh_pkg::TS_LEN - pos_q), 3'b000};
  assign ro        = (cfg_s2x_q & tog_q) ? 2'b11 : cfg_ro_q;

  // handshake
  assign out_acc    = run_vld_q & !out_stall_i;
  assign in_stall_o = run_vld_q & !(run_last & out_acc);
  assign in_acc     = in_valid_i & !in_stall_o;

  // stream state update on an accepted word
  always_comb begin
    pos_d  = pos_q;
    pcrc_d = pcrc_q;
    fbc_d  = fbc_q;
    grp_d  = grp_q;
    tog_d  = tog_q;
    pend_d = pend_q;
    if (in_acc) begin
      pend_d = run_any ? 1'b0 : err;
      pos_d  = (pos_q == tsbbh_pkg::TS_LEN - 8'd1) ? 8'd0 : pos_q + 8'd1;
      if (at_start) begin
        if (!cfg_he_q) begin
          pcrc_d = '0;
        end
      end else if (!cfg_he_q) begin
        pcrc_d = tsbbh_pkg::crc8_byte(pcrc_q, ts_byte_i);
      end
      if (hdr_due && cfg_s2x_q) begin
        tog_d = !tog_q;
      end
      fbc_d = has_data ? fbc_inc : fbc_base;
      if (frame_end) begin
        fbc_d = '0;
        if (cfg_iben_q) begin
          grp_d = (grp_inc >= {1'b0, cfg_fpg_q}) ? 8'd0 : grp_inc[7:0];
        end
      end
    end
  end

  // current output word
  logic [7:0] hdr_byte;
  logic [15:0] upl;
  assign upl = cfg_he_q ? 16'd0 : tsbbh_pkg::UPL_TS;

  always_comb begin
    case (cnt_q)
      4'd0:    hdr_byte = run_m1_q;
      4'd1:    hdr_byte = 8'd0;
      4'd2:    hdr_byte = upl[15:8];
      4'd3:    hdr_byte = upl[7:0];
      4'd4:    hdr_byte = run_dfl_q[15:8];
      4'd5:    hdr_byte = run_dfl_q[7:0];
      4'd6:    hdr_byte = cfg_he_q ? 8'd0 : tsbbh_pkg::TS_SYNC;
      4'd7:    hdr_byte = {5'd0, run_syncd_q[10:8]};
      4'd8:    hdr_byte = run_syncd_q[7:0];
      default: hdr_byte = hcrc_q ^ {7'd0, cfg_he_q};
    endcase
  end

  always_comb begin
    case (seg_q)
      tsbbh_pkg::SEG_HDR: begin
        out_byte_o  = hdr_byte;
        byte_kind_o = tsbbh_pkg::KIND_HDR;
        run_last    = (cnt_q == 4'(tsbbh_pkg::HDR_BYTES - 1)) & !run_dat_q;
      end
      tsbbh_pkg::SEG_DAT: begin
        out_byte_o  = run_byte_q;
        byte_kind_o = tsbbh_pkg::KIND_DATA;
        run_last    = !run_inb_q;
      end
      tsbbh_pkg::SEG_INB: begin
        out_byte_o  = tsbbh_pkg::inband_byte(cfg_rate_q, cnt_q);
        byte_kind_o = tsbbh_pkg::KIND_INB;
        run_last    = (cnt_q == 4'(tsbbh_pkg::INB_BYTES - 1));
      end
      default: begin
        out_byte_o  = run_byte_q;
        byte_kind_o = tsbbh_pkg::KIND_DATA;
        run_last    = 1'b1;
      end
    endcase
  end

  assign out_valid_o   = run_vld_q;
  assign last_of_run_o = run_last;
  assign sync_error_o  = run_err_q;

  // output sequencer
  always_comb begin
    run_vld_d = run_vld_q;
    seg_d     = seg_q;
    cnt_d     = cnt_q;
    hcrc_d    = hcrc_q;
    if (out_acc) begin
      cnt_d = cnt_q + 4'd1;
      case (seg_q)
        tsbbh_pkg::SEG_HDR: begin
          hcrc_d = tsbbh_pkg::crc8_byte(hcrc_q, hdr_byte);
          if (cnt_q == 4'(tsbbh_pkg::HDR_BYTES - 1)) begin
            seg_d     = tsbbh_pkg::SEG_DAT;
            cnt_d     = '0;
            run_vld_d = run_dat_q;
          end
        end
        tsbbh_pkg::SEG_DAT: begin
          seg_d     = tsbbh_pkg::SEG_INB;
          cnt_d     = '0;
          run_vld_d = run_inb_q;
        end
        default: begin
          if (run_last) begin
            run_vld_d = 1'b0;
          end
        end
      endcase
    end
    if (in_acc) begin
      run_vld_d = run_any;
      cnt_d     = '0;
      hcrc_d    = '0;
      seg_d     = hdr_due ? tsbbh_pkg::SEG_HDR : tsbbh_pkg::SEG_DAT;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      pcrc_q    <= '0;
      fbc_q     <= '0;
      grp_q     <= '0;
      tog_q     <= 1'b1;
      pend_q    <= 1'b0;
      run_vld_q <= 1'b0;
      seg_q     <= tsbbh_pkg::SEG_DAT;
      cnt_q     <= '0;
      hcrc_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      pcrc_q    <= pcrc_d;
      fbc_q     <= fbc_d;
      grp_q     <= grp_d;
      tog_q     <= tog_d;
      pend_q    <= pend_d;
      run_vld_q <= run_vld_d;
      seg_q     <= seg_d;
      cnt_q     <= cnt_d;
      hcrc_q    <= hcrc_d;
    end
  end

  // run payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      run_dat_q   <= has_data;
      run_inb_q   <= frame_end & inb_now;
      run_err_q   <= err;
      run_byte_q  <= data_b;
      run_m1_q    <= {cfg_mat_q, ro};
      run_dfl_q   <= {pb, 3'b000};
      run_syncd_q <= syncd;
    end
  end

endmodule
